### src/crgl_pkg.sv
`default_nettype none
package crgl_pkg;

  // Field widths
  localparam int CODE_W  = 21;
  localparam int GLYPH_W = 16;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;

  // Default table depth
  localparam int DEF_MAX_GROUPS = 256;

  // Stream packing: entry_index, range_start, range_end, first_glyph, char_code
  localparam int IN_BITS   = INDEX_W + 3 * CODE_W + GLYPH_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = GLYPH_W;

  localparam int IDX_LSB   = 0;
  localparam int START_LSB = IDX_LSB + INDEX_W;
  localparam int END_LSB   = START_LSB + CODE_W;
  localparam int GLYPH_LSB = END_LSB + CODE_W;
  localparam int CODE_LSB  = GLYPH_LSB + GLYPH_W;

  // Request kinds on tuser
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // One range group as stored in the table
  typedef struct packed {
    logic [GLYPH_W-1:0] first_glyph;
    logic [CODE_W-1:0]  range_end;
    logic [CODE_W-1:0]  range_start;
  } group_entry_t;

  localparam int ENTRY_W = $bits(group_entry_t);

  // Search sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### src/crgl_ram.sv
`default_nettype none
module crgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/char_range_group_lookup_core.sv
`default_nettype none
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   lookup or load request
// m_axis    out  m_axis_tvalid/m_axis_tready   glyph result, one per lookup
// cfg       in   cfg_wr_en                     group_count register
//
// A load writes the group to the table at acceptance.
// A lookup passes acceptance, n binary search steps, then the hand-off to the
// output register once it is free; n = 0 when group_count is 0, else 1 up to
// log2(MAX_GROUPS)+1 (9 for 256 groups), one registered table read per step.
// Reset clears the sequencer, the output valid flag and group_count, not the table.
// s_axis_tready is low while a search runs or while a finished result waits.
module char_range_group_lookup_core #(
  parameter int MAX_GROUPS = crgl_pkg::DEF_MAX_GROUPS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_axis_tdata: entry_index, range_start, range_end, first_glyph, char_code, pad
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [crgl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: mode
  input  wire logic [0:0]                      s_axis_tuser,
  // m_axis_tdata: glyph_index
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [crgl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: found
  output logic      [0:0]                      m_axis_tuser,
  input  wire logic                            cfg_wr_en,
  input  wire logic [crgl_pkg::COUNT_W-1:0]    cfg_wr_data
);

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int HW = $clog2(MAX_GROUPS + 1);

  crgl_pkg::state_t state, state_next;

  logic [crgl_pkg::COUNT_W-1:0] group_count;
  logic [HW-1:0]                limit;
  logic [HW-1:0]                lo, hi, mid;
  logic [HW-1:0]                lo_next, hi_next, mid_next;
  logic [HW:0]                  span_sum;
  logic [crgl_pkg::CODE_W-1:0]  code;
  logic                         in_fire, is_load, is_lookup;
  logic                         load_ok;
  logic                         go_left, go_right, hit, search_end;
  logic [crgl_pkg::GLYPH_W-1:0] hit_glyph;
  logic [crgl_pkg::GLYPH_W-1:0] res_glyph;
  logic                         res_found;
  logic                         out_valid;
  logic                         out_free;

  logic [AW-1:0]                  rd_addr, wr_addr;
  crgl_pkg::group_entry_t         wr_entry, rd_entry;
  logic [crgl_pkg::ENTRY_W-1:0]   rd_bits;

  // Request decode
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign is_load   = s_axis_tuser[0] == crgl_pkg::MODE_LOAD;
  assign is_lookup = s_axis_tuser[0] == crgl_pkg::MODE_LOOKUP;
  assign load_ok   = int'(s_axis_tdata[crgl_pkg::IDX_LSB +: crgl_pkg::INDEX_W]) < MAX_GROUPS;
  assign wr_addr   = AW'(s_axis_tdata[crgl_pkg::IDX_LSB +: crgl_pkg::INDEX_W]);
  assign wr_entry.range_start = s_axis_tdata[crgl_pkg::START_LSB +: crgl_pkg::CODE_W];
  assign wr_entry.range_end   = s_axis_tdata[crgl_pkg::END_LSB +: crgl_pkg::CODE_W];
  assign wr_entry.first_glyph = s_axis_tdata[crgl_pkg::GLYPH_LSB +: crgl_pkg::GLYPH_W];

  // Searched slot count, clamped to the table depth
  assign limit = (int'(group_count) > MAX_GROUPS) ? HW'(MAX_GROUPS) : HW'(group_count);

  // Group table
  crgl_ram #(
    .WIDTH (crgl_pkg::ENTRY_W),
    .DEPTH (MAX_GROUPS)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_fire && is_load && load_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );
  assign rd_entry = crgl_pkg::group_entry_t'(rd_bits);

  // Compare unit: one probe of the current midpoint per cycle
  assign go_left   = code < rd_entry.range_start;
  assign go_right  = !go_left && (code > rd_entry.range_end);
  assign hit       = !go_left && !go_right;
  assign lo_next   = go_right ? HW'(mid + 1'b1) : lo;
  assign hi_next   = go_left ? mid : hi;
  assign span_sum  = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next  = span_sum[HW:1];
  assign search_end = hit || !(lo_next < hi_next);
  assign hit_glyph = rd_entry.first_glyph
                   + (code[crgl_pkg::GLYPH_W-1:0]
                      - rd_entry.range_start[crgl_pkg::GLYPH_W-1:0]);

  // Read address: first probe is issued while idle, later ones from the compare
  always_comb begin
    if (state == crgl_pkg::ST_SEARCH) begin
      rd_addr = AW'(mid_next);
    end else begin
      rd_addr = AW'(limit >> 1);
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      crgl_pkg::ST_IDLE: begin
        if (in_fire && is_lookup) begin
          state_next = (limit == '0) ? crgl_pkg::ST_DONE : crgl_pkg::ST_SEARCH;
        end
      end
      crgl_pkg::ST_SEARCH: begin
        if (search_end) begin
          state_next = crgl_pkg::ST_DONE;
        end
      end
      crgl_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = crgl_pkg::ST_IDLE;
        end
      end
      default: state_next = crgl_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state == crgl_pkg::ST_IDLE);
    m_axis_tvalid = out_valid;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crgl_pkg::ST_IDLE;
      group_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        group_count <= cfg_wr_data;
      end
      if (state == crgl_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search bounds and result
  always_ff @(posedge clk) begin
    if (state == crgl_pkg::ST_IDLE && in_fire && is_lookup) begin
      code      <= s_axis_tdata[crgl_pkg::CODE_LSB +: crgl_pkg::CODE_W];
      lo        <= '0;
      hi        <= limit;
      mid       <= limit >> 1;
      res_glyph <= '0;
      res_found <= 1'b0;
    end else if (state == crgl_pkg::ST_SEARCH) begin
      lo        <= lo_next;
      hi        <= hi_next;
      mid       <= mid_next;
      res_glyph <= hit ? hit_glyph : '0;
      res_found <= hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == crgl_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= res_glyph;
      m_axis_tuser <= res_found;
    end
  end

  // Checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss result carries a nonzero glyph");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    state == crgl_pkg::ST_SEARCH |-> (lo < hi) && (hi <= limit))
    else $error("search bounds out of order");

  a_mid_in: assert property (@(posedge clk) disable iff (rst)
    state == crgl_pkg::ST_SEARCH |-> (mid >= lo) && (mid < hi))
    else $error("probe outside search window");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_lookup |=> !s_axis_tready)
    else $error("lookup accepted without starting a search");

endmodule
`default_nettype wire

### tb/char_range_group_lookup_core_test.sv
module char_range_group_lookup_core_test;
  import crgl_pkg::*;

  localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  // One lookup answer: glyph index and hit flag
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               found;
  } glyph_result_t;

  // Mirror of the group table, the count register and the pending answers
  class glyph_scoreboard;
    group_entry_t groups[DEF_MAX_GROUPS];
    logic [COUNT_W-1:0] group_count = '0;
    glyph_result_t expected_glyphs[$];
    int mismatches = 0;

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Fixed binary search over the active slots
    function glyph_result_t search_groups(input logic [CODE_W-1:0] code);
      int unsigned lo, hi, mid;
      logic [CODE_W-1:0] offset;
      group_entry_t ent;
      glyph_result_t res;
      res = '0;
      lo = 0;
      hi = (group_count > DEF_MAX_GROUPS) ? DEF_MAX_GROUPS : group_count;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        ent = groups[mid];
        if (code < ent.range_start) begin
          hi = mid;
        end else if (code > ent.range_end) begin
          lo = mid + 1;
        end else begin
          offset = code - ent.range_start;
          res.glyph = ent.first_glyph + offset[GLYPH_W-1:0];
          res.found = 1'b1;
          return res;
        end
      end
      return res;
    endfunction

    // Accepted request: loads update the table, lookups queue an answer
    function void note_request(input logic mode, input logic [IN_DATA_W-1:0] data);
      group_entry_t ent;
      if (mode == MODE_LOAD) begin
        ent.range_start = data[START_LSB +: CODE_W];
        ent.range_end   = data[END_LSB +: CODE_W];
        ent.first_glyph = data[GLYPH_LSB +: GLYPH_W];
        groups[data[IDX_LSB +: INDEX_W]] = ent;
      end else begin
        expected_glyphs.insert(expected_glyphs.size(),
                               search_groups(data[CODE_LSB +: CODE_W]));
      end
    endfunction

    task check_glyph(input logic [GLYPH_W-1:0] glyph, input logic found);
      glyph_result_t want;
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected result glyph %h found %b", glyph, found));
        return;
      end
      want = expected_glyphs.pop_front();
      if (glyph !== want.glyph)
        report_mismatch($sformatf("glyph_index %h, want %h", glyph, want.glyph));
      if (found !== want.found)
        report_mismatch($sformatf("found %b, want %b", found, want.found));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]    cfg_wr_data = '0;

  glyph_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;

  char_range_group_lookup_core #(
    .MAX_GROUPS(DEF_MAX_GROUPS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check, then pick tready (random stall or long hold-off)
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_glyph(m_axis_tdata, m_axis_tuser[0]);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [CODE_W-1:0] random_code();
    return CODE_W'($urandom_range(0, CODE_MAX));
  endfunction

  // Offer one request after a random idle gap, return once it is taken
  task automatic send_request(input logic mode, input logic [INDEX_W-1:0] slot,
                              input logic [CODE_W-1:0] start_code,
                              input logic [CODE_W-1:0] end_code,
                              input logic [GLYPH_W-1:0] glyph,
                              input logic [CODE_W-1:0] code);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[IDX_LSB +: INDEX_W]   = slot;
    data[START_LSB +: CODE_W]  = start_code;
    data[END_LSB +: CODE_W]    = end_code;
    data[GLYPH_LSB +: GLYPH_W] = glyph;
    data[CODE_LSB +: CODE_W]   = code;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(mode, data);
  endtask

  // Load: char_code field carries noise
  task automatic send_load(input logic [INDEX_W-1:0] slot, input logic [CODE_W-1:0] lo_code,
                           input logic [CODE_W-1:0] hi_code, input logic [GLYPH_W-1:0] glyph);
    send_request(MODE_LOAD, slot, lo_code, hi_code, glyph, random_code());
  endtask

  // Lookup: load fields carry noise
  task automatic send_lookup(input logic [CODE_W-1:0] code);
    send_request(MODE_LOOKUP, INDEX_W'($urandom), random_code(), random_code(),
                 GLYPH_W'($urandom), code);
  endtask

  // Drop valid, wait for all answers, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_count(input logic [COUNT_W-1:0] count);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.group_count = count;
  endtask

  // Sorted, non-overlapping groups in slots 0..n-1 spread over the code space
  task automatic build_groups(input int n);
    int unsigned budget, cursor, gap, len;
    int i;
    budget = 32'h110000 / n;
    cursor = 0;
    for (i = 0; i < n; i++) begin
      gap = $urandom_range(0, budget / 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      len = $urandom_range(0, budget - gap - 1);
      if ($urandom_range(0, 3) == 0) len = 0;
      send_load(INDEX_W'(i), CODE_W'(cursor + gap), CODE_W'(cursor + gap + len),
                GLYPH_W'($urandom));
      cursor = cursor + gap + len + 1;
    end
  endtask

  // Mostly lookups aimed at the active groups, some loads and noise
  task automatic run_mix(input int n_items);
    int k, active, pick, slot;
    group_entry_t g;
    logic [CODE_W-1:0] code;
    for (k = 0; k < n_items; k++) begin
      active = (sb.group_count > DEF_MAX_GROUPS) ? DEF_MAX_GROUPS : sb.group_count;
      slot = $urandom_range(0, (active == 0) ? DEF_MAX_GROUPS - 1 : active - 1);
      g = sb.groups[slot];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // new glyph base, codes unchanged
        send_load(INDEX_W'(slot), g.range_start, g.range_end, GLYPH_W'($urandom));
      end else if (pick < 12) begin
        // arbitrary group anywhere: may unsort or reverse
        send_load(INDEX_W'($urandom), random_code(), random_code(), GLYPH_W'($urandom));
      end else begin
        code = random_code();
        if (pick < 60) begin
          if (g.range_end >= g.range_start)
            code = g.range_start + CODE_W'($urandom_range(0, g.range_end - g.range_start));
        end else if (pick < 75) begin
          case ($urandom_range(0, 3))
            0: code = g.range_start;
            1: code = g.range_end;
            2: if (g.range_start != 0) code = g.range_start - 1;
            default: if (g.range_end < CODE_MAX) code = g.range_end + 1;
          endcase
        end
        send_lookup(code);
      end
    end
  endtask

  initial begin
    group_entry_t g;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty search range: everything misses
    send_lookup('0);
    send_lookup(CODE_MAX);

    build_groups(DEF_MAX_GROUPS);
    write_group_count(COUNT_W'(DEF_MAX_GROUPS));

    // code 0 at slot 0 with the top glyph, next code wraps to glyph 0
    g = sb.groups[0];
    send_load('0, '0, g.range_end, 16'hFFFF);
    send_lookup('0);
    send_lookup(21'd1);
    // last slot reaches the top code
    g = sb.groups[DEF_MAX_GROUPS-1];
    send_load(INDEX_W'(DEF_MAX_GROUPS - 1), g.range_start, CODE_MAX, 16'h0000);
    send_lookup(CODE_MAX);
    // group edges and the codes just outside
    g = sb.groups[100];
    send_lookup(g.range_start);
    send_lookup(g.range_end);
    send_lookup(g.range_start - 1);
    send_lookup(g.range_end + 1);
    // reversed group covers nothing; search moves right past it
    g = sb.groups[128];
    send_load(8'd128, g.range_end, g.range_start - 1, GLYPH_W'($urandom));
    send_lookup(g.range_start);
    send_lookup(sb.groups[129].range_start);
    send_load(8'd128, g.range_start, g.range_end, g.first_glyph);
    // out-of-order group in the middle of the table
    g = sb.groups[64];
    send_load(8'd64, 21'h100000, CODE_MAX, 16'h1234);
    send_lookup(21'h100005);
    send_lookup(g.range_start);
    send_load(8'd64, g.range_start, g.range_end, g.first_glyph);

    // full table, no idling, then a long receiver hold-off
    run_mix(150);
    hold_request = 300;
    run_mix(60);

    send_idle_pct = 66;
    run_mix(150);

    // few wide groups
    send_idle_pct = 0;
    recv_stall_pct = 66;
    build_groups(16);
    write_group_count(9'd16);
    run_mix(150);

    // one group, up to the full code space wide
    send_idle_pct = 25;
    recv_stall_pct = 25;
    build_groups(1);
    write_group_count(9'd1);
    run_mix(120);

    write_group_count(9'd0);
    run_mix(60);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    build_groups(DEF_MAX_GROUPS);
    write_group_count(9'd200);
    run_mix(120);

    // counts above the table depth are clamped
    send_idle_pct = 66;
    write_group_count(9'd511);
    run_mix(120);

    send_idle_pct = 0;
    recv_stall_pct = 66;
    write_group_count(9'd300);
    run_mix(150);

    send_idle_pct = 25;
    recv_stall_pct = 25;
    write_group_count(COUNT_W'(DEF_MAX_GROUPS));
    run_mix(130);

    wait_idle();
    if (sb.expected_glyphs.size() != 0)
      sb.report_mismatch($sformatf("%0d lookups never answered", sb.expected_glyphs.size()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/crgl_pkg.sv
src/crgl_ram.sv
src/char_range_group_lookup_core.sv
tb/char_range_group_lookup_core_test.sv
